// ----- sv/rbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbc_pkg;
  typedef enum logic [3:0] {
    ST_IDLE, ST_DIFF, ST_DIVX, ST_DIVY, ST_MEAN, ST_SQX, ST_SQY,
    ST_CROSS, ST_DIVC, ST_VARX, ST_VARY, ST_FIN, ST_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- sv/rbc_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbc_div import rbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [63:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             done,
  output logic [63:0]      quotient
);
  logic [6:0]  cnt;
  logic [32:0] rem;
  logic        busy;
  logic [33:0] trial;

  assign trial = {rem, quotient[63]} - {2'b0, divisor};

  // One quotient bit per cycle, restoring.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= 7'd64;
        rem      <= '0;
        quotient <= dividend;
      end else if (busy) begin
        if (!trial[33]) begin
          rem      <= trial[32:0];
          quotient <= {quotient[62:0], 1'b1};
        end else begin
          rem      <= {rem[31:0], quotient[63]};
          quotient <= {quotient[62:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

// ----- sv/running_bivariate_covariance_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Running bivariate mean, variance and covariance (Welford).
// Input channel: x_sample, y_sample, last_sample with in_valid/in_ready.
// Output channel: pair_count, means, variances, covariance, series_end
// with out_valid/out_ready.
// One item at a time: in_ready is high only when idle. Each item runs
// five divisions by the count on one shared serial divider, plus the
// square-sum and cross-term multiply steps, before its result is formed.
// The result is held in output registers until taken; a stalled receiver
// keeps the block from accepting the next item.
// Reset (rst, synchronous) clears count, means and accumulators. An item
// flagged last clears them after its result is formed.
module running_bivariate_covariance_core import rbc_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  parameter int COUNT_WIDTH  = 32
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [31:0]      x_sample,
  input  wire logic signed [31:0]      y_sample,
  input  wire logic                    last_sample,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [31:0]                  pair_count,
  output logic signed [31:0]           x_mean,
  output logic signed [31:0]           y_mean,
  output logic [62:0]                  x_variance,
  output logic [62:0]                  y_variance,
  output logic signed [63:0]           covariance,
  output logic                         series_end
);
  localparam logic [63:0] S64MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEGLIM = 64'h8000_0000_0000_0000;
  localparam logic [32:0] CMAX   = (33'd1 << COUNT_WIDTH) - 33'd1;

  state_t state, state_next;
  logic [31:0] cnt;
  logic signed [32:0] mx, my, xs, ys;
  logic signed [33:0] dx, dy;
  logic signed [33:0] qx, qy;
  logic [63:0] ssx, ssy;
  logic signed [63:0] cacc;
  logic last;
  logic dv_start, dv_done;
  logic [63:0] dv_a, dv_q;
  logic waiting;

  rbc_div u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(dv_a),
    .divisor(cnt), .done(dv_done), .quotient(dv_q)
  );

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  // Square-sum step operands (shared multiplier).
  logic signed [33:0] ex, ey;
  logic [33:0] ma, mb;
  logic [67:0] mp;
  logic [67:0] ps;
  logic [64:0] ssum;
  assign ex = 34'(xs) - 34'(mx);
  assign ey = 34'(ys) - 34'(my);
  assign ma = (state == ST_SQX) ? (dx[33] ? 34'(-dx) : dx) :
              (state == ST_SQY) ? (dy[33] ? 34'(-dy) : dy) :
                                  (qx[33] ? 34'(-qx) : qx);
  assign mb = (state == ST_SQX) ? (ex[33] ? 34'(-ex) : ex) :
              (state == ST_SQY) ? (ey[33] ? 34'(-ey) : ey) :
                                  (qy[33] ? 34'(-qy) : qy);
  assign mp = ma * mb;
  assign ps = mp >> FRAC_BITS;

  // Cross term: (n-1)*|qx*qy| >> FRAC in two 32x32 halves.
  logic [63:0] prod;
  logic [31:0] km1;
  logic [63:0] lo, hi;
  logic [63:0] cm, tail, part;
  logic        cneg;
  logic [63:0] cmag;
  assign km1 = cnt - 32'd1;
  assign lo = {32'd0, prod[31:0]} * {32'd0, km1};
  assign hi = {32'd0, prod[63:32]} * {32'd0, km1};
  assign tail = lo >> FRAC_BITS;
  assign part = hi << (32 - FRAC_BITS);
  always_comb begin
    if (hi > (NEGLIM >> (32 - FRAC_BITS))) cm = NEGLIM;
    else if (part > NEGLIM - tail)         cm = NEGLIM;
    else                                   cm = part + tail;
  end
  logic [63:0] term_r;
  logic        tneg;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_DIFF;
      ST_DIFF:  state_next = ST_DIVX;
      ST_DIVX:  if (dv_done) state_next = ST_DIVY;
      ST_DIVY:  if (dv_done) state_next = ST_MEAN;
      ST_MEAN:  state_next = ST_SQX;
      ST_SQX:   state_next = ST_SQY;
      ST_SQY:   state_next = ST_CROSS;
      ST_CROSS: state_next = ST_DIVC;
      ST_DIVC:  if (dv_done) state_next = ST_VARX;
      ST_VARX:  if (dv_done) state_next = ST_VARY;
      ST_VARY:  if (dv_done) state_next = ST_FIN;
      ST_FIN:   state_next = ST_OUT;
      ST_OUT:   if (out_ready) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    dv_start = 1'b0;
    dv_a = '0;
    case (state)
      ST_DIVX: begin dv_start = !waiting; dv_a = mag(64'(dx)); end
      ST_DIVY: begin dv_start = !waiting; dv_a = mag(64'(dy)); end
      ST_DIVC: begin dv_start = !waiting; dv_a = cmag; end
      ST_VARX: begin dv_start = !waiting; dv_a = ssx; end
      ST_VARY: begin dv_start = !waiting; dv_a = ssy; end
      default: ;
    endcase
  end

  logic [64:0] sadd;
  logic [63:0] shrunk;
  logic [64:0] nq;
  always_comb begin
    ssum = (state == ST_SQX) ? 65'(ssx) + 65'(ps[63:0]) : 65'(ssy) + 65'(ps[63:0]);
    if (ps[67:64] != 0) ssum = {1'b1, 64'd0};
    nq = 65'(cmag) - 65'(dv_q);
    if (!cneg) shrunk = (nq[63:0] > S64MAX) ? S64MAX : nq[63:0];
    else if (nq[63:0] >= NEGLIM) shrunk = NEGLIM;
    else shrunk = 64'(-nq[63:0]);
    sadd = {shrunk[63], shrunk} + {term_r[63], term_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      waiting <= 1'b0;
      cnt <= '0; mx <= '0; my <= '0; ssx <= '0; ssy <= '0; cacc <= '0;
    end else begin
      state <= state_next;
      if (dv_start) waiting <= 1'b1;
      if (dv_done) waiting <= 1'b0;
      case (state)
        ST_IDLE: if (in_valid) begin
          xs <= 33'(signed'(x_sample[SAMPLE_WIDTH-1:0]));
          ys <= 33'(signed'(y_sample[SAMPLE_WIDTH-1:0]));
          last <= last_sample;
          if (33'(cnt) < CMAX) cnt <= cnt + 32'd1;
        end
        ST_DIFF: begin dx <= 34'(xs) - 34'(mx); dy <= 34'(ys) - 34'(my); end
        ST_DIVX: if (dv_done) qx <= dx[33] ? 34'(-dv_q[33:0]) : dv_q[33:0];
        ST_DIVY: if (dv_done) qy <= dy[33] ? 34'(-dv_q[33:0]) : dv_q[33:0];
        ST_MEAN: begin
          mx <= 33'(34'(mx) + qx);
          my <= 33'(34'(my) + qy);
          // multiplier holds |qx|*|qy| here
          prod <= mp[63:0];
          tneg <= qx[33] ^ qy[33];
        end
        ST_SQX: ssx <= ssum[64] ? '1 : ssum[63:0];
        ST_SQY: ssy <= ssum[64] ? '1 : ssum[63:0];
        ST_CROSS: begin
          if (tneg && cm != 0) term_r <= (cm >= NEGLIM) ? NEGLIM : 64'(-cm);
          else term_r <= (cm > S64MAX) ? S64MAX : cm;
          cneg <= cacc[63];
          cmag <= mag(cacc);
        end
        ST_DIVC: if (dv_done) begin
          if (sadd[64] != sadd[63]) cacc <= sadd[64] ? NEGLIM : S64MAX;
          else cacc <= sadd[63:0];
        end
        ST_VARX: if (dv_done) x_variance <= dv_q[63] ? S64MAX[62:0] : dv_q[62:0];
        ST_VARY: if (dv_done) y_variance <= dv_q[63] ? S64MAX[62:0] : dv_q[62:0];
        ST_FIN: begin
          pair_count <= cnt;
          x_mean <= mx[31:0];
          y_mean <= my[31:0];
          covariance <= cacc;
          series_end <= last;
          if (last) begin
            cnt <= '0; mx <= '0; my <= '0; ssx <= '0; ssy <= '0; cacc <= '0;
          end
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- test/running_bivariate_covariance_core_tb.sv -----
`timescale 1ns / 1ps
module running_bivariate_covariance_core_tb;
  import rbc_pkg::*;

  localparam int unsigned QUIET_LIMIT = 20000;
  localparam int unsigned HOLDOFF_CYCLES = 2000;
  localparam logic [63:0] POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_MAX = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [31:0] cnt;
    logic [31:0] mx;
    logic [31:0] my;
    logic [62:0] vx;
    logic [62:0] vy;
    logic [63:0] cov;
    logic        fin;
  } stats_t;

  typedef struct packed {
    logic [31:0] xs;
    logic [31:0] ys;
    logic        last;
    logic        typed;
    stats_t      want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] x_sample = '0;
  logic signed [31:0] y_sample = '0;
  logic last_sample = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] pair_count;
  logic signed [31:0] x_mean;
  logic signed [31:0] y_mean;
  logic [62:0] x_variance;
  logic [62:0] y_variance;
  logic signed [63:0] covariance;
  logic series_end;

  running_bivariate_covariance_core u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .x_sample(x_sample), .y_sample(y_sample), .last_sample(last_sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .pair_count(pair_count), .x_mean(x_mean), .y_mean(y_mean),
    .x_variance(x_variance), .y_variance(y_variance),
    .covariance(covariance), .series_end(series_end)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // running statistics of the series in flight
  logic [63:0] pairs_seen;
  longint signed avg_x, avg_y, cov_acc;
  logic [63:0] dev_sq_x, dev_sq_y;

  stats_t pending_stats[$];
  int unsigned fail_count = 0;
  int unsigned results_taken = 0;
  int unsigned quiet_cycles = 0;
  bit sending_done = 1'b0;

  function automatic logic [63:0] abs64(input longint signed v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint signed clamp_signed(input logic neg, input logic [63:0] m);
    if (!neg) return (m > POS_MAX) ? POS_MAX : m;
    if (m >= NEG_MAX) return NEG_MAX;
    return -$signed(m);
  endfunction

  function automatic longint signed step_mean(input longint signed s,
      inout longint signed avg, inout logic [63:0] dev_sq, input logic [63:0] n);
    longint signed d, q;
    logic [63:0] p;
    d = s - avg;
    q = d / $signed(n);
    avg = avg + q;
    p = (abs64(d) * abs64(s - avg)) >> 16;
    dev_sq = (dev_sq > ~64'd0 - p) ? ~64'd0 : dev_sq + p;
    return q;
  endfunction

  function automatic logic [62:0] var_of(input logic [63:0] ssum, input logic [63:0] n);
    logic [63:0] v;
    v = ssum / n;
    return (v > POS_MAX) ? POS_MAX[62:0] : v[62:0];
  endfunction

  function automatic stats_t welford_update(input logic [31:0] xs, input logic [31:0] ys,
      input logic last);
    stats_t r;
    longint signed qx, qy, term, shrunk;
    logic [63:0] prod, lo, hi, tail, cm, cmag;
    logic [64:0] sum;
    if (pairs_seen < 64'hFFFF_FFFF) pairs_seen++;
    qx = step_mean($signed(xs), avg_x, dev_sq_x, pairs_seen);
    qy = step_mean($signed(ys), avg_y, dev_sq_y, pairs_seen);
    prod = abs64(qx) * abs64(qy);
    lo = {32'd0, prod[31:0]} * (pairs_seen - 1);
    hi = (prod >> 32) * (pairs_seen - 1);
    tail = lo >> 16;
    if (hi > (NEG_MAX >> 16)) cm = NEG_MAX;
    else if ((hi << 16) > NEG_MAX - tail) cm = NEG_MAX;
    else cm = (hi << 16) + tail;
    term = clamp_signed(((qx < 0) != (qy < 0)) && cm != 0, cm);
    cmag = abs64(cov_acc);
    shrunk = clamp_signed(cov_acc < 0, cmag - cmag / pairs_seen);
    sum = {shrunk[63], shrunk} + {term[63], term};
    if (sum[64] != sum[63]) cov_acc = sum[64] ? NEG_MAX : POS_MAX;
    else cov_acc = sum[63:0];
    r.cnt = pairs_seen[31:0];
    r.mx = avg_x[31:0];
    r.my = avg_y[31:0];
    r.vx = var_of(dev_sq_x, pairs_seen);
    r.vy = var_of(dev_sq_y, pairs_seen);
    r.cov = cov_acc;
    r.fin = last;
    if (last) clear_series();
    return r;
  endfunction

  function automatic void clear_series();
    pairs_seen = 0;
    avg_x = 0;
    avg_y = 0;
    dev_sq_x = 0;
    dev_sq_y = 0;
    cov_acc = 0;
  endfunction

  localparam stats_t NO_STATS = '0;
  localparam int NUM_ROWS = 16;
  // typed rows: first pair of a series leaves mean at the sample, zero spread
  localparam row_t DIRECTED [NUM_ROWS] = '{
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b1, '{32'd1, 32'd0, 32'd0, 63'd0, 63'd0, 64'd0, 1'b1}},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b1,
      '{32'd1, 32'h7FFF_FFFF, 32'h8000_0000, 63'd0, 63'd0, 64'd0, 1'b0}},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_STATS},
    '{32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, NO_STATS},
    '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_STATS},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b1,
      '{32'd1, 32'h8000_0000, 32'h8000_0000, 63'd0, 63'd0, 64'd0, 1'b0}},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b0, NO_STATS},
    '{32'h8000_0000, 32'h8000_0000, 1'b0, 1'b0, NO_STATS},
    '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b0, NO_STATS},
    '{32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 1'b1,
      '{32'd1, 32'hFFFF_FFFF, 32'h0000_0001, 63'd0, 63'd0, 64'd0, 1'b0}},
    '{32'h0001_0000, 32'hFFFF_0000, 1'b0, 1'b0, NO_STATS},
    '{32'h0003_0000, 32'h0005_0000, 1'b0, 1'b0, NO_STATS},
    '{32'hFFFD_0000, 32'h0000_8000, 1'b1, 1'b0, NO_STATS},
    '{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, NO_STATS},
    '{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 1'b0, NO_STATS},
    '{32'h0000_0000, 32'h0000_0000, 1'b1, 1'b0, NO_STATS}
  };

  function automatic logic [31:0] draw_sample();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      1, 2: return $urandom;
      default: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
    endcase
  endfunction

  task automatic send_pair(input logic [31:0] xs, input logic [31:0] ys, input logic last,
      input bit busy_mode, input bit typed, input stats_t want);
    stats_t got;
    int unsigned gap;
    gap = busy_mode ? 0 : $urandom_range(0, 3);
    // drop valid only when idling before the next item
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_sample <= xs;
    y_sample <= ys;
    last_sample <= last;
    do @(posedge clk); while (!in_ready);
    got = welford_update(xs, ys, last);
    pending_stats.push_back(typed ? want : got);
  endtask

  initial begin
    int unsigned sent;
    int unsigned run_len;
    bit busy_mode;
    clear_series();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (DIRECTED[i])
      send_pair(DIRECTED[i].xs, DIRECTED[i].ys, DIRECTED[i].last, 1'b0,
                DIRECTED[i].typed, DIRECTED[i].want);
    sent = 0;
    while (sent < 1950) begin
      run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 12);
      busy_mode = ($urandom_range(0, 3) == 0);
      for (int unsigned k = 1; k <= run_len; k++) begin
        send_pair(draw_sample(), draw_sample(), k == run_len, busy_mode, 1'b0, NO_STATS);
        sent++;
      end
    end
    in_valid <= 1'b0;
    sending_done = 1'b1;
  end

  // receiver: random stalls, one long hold-off to back the block up
  initial begin
    int unsigned stall;
    bit held = 1'b0;
    @(negedge rst);
    forever begin
      if (!held && results_taken >= 500) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLDOFF_CYCLES) @(posedge clk);
      end
      stall = ((results_taken / 64) % 4 == 1) ? 0 : $urandom_range(0, 3);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    stats_t e;
    if (!rst && out_valid && out_ready) begin
      results_taken++;
      if (pending_stats.size() == 0) begin
        $error("result with no pending item: count %0d", pair_count);
        fail_count++;
      end else begin
        e = pending_stats.pop_front();
        if (pair_count !== e.cnt) begin
          $error("pair_count exp %0d got %0d", e.cnt, pair_count); fail_count++;
        end
        if (x_mean !== e.mx) begin
          $error("x_mean exp %0h got %0h", e.mx, x_mean); fail_count++;
        end
        if (y_mean !== e.my) begin
          $error("y_mean exp %0h got %0h", e.my, y_mean); fail_count++;
        end
        if (x_variance !== e.vx) begin
          $error("x_variance exp %0h got %0h", e.vx, x_variance); fail_count++;
        end
        if (y_variance !== e.vy) begin
          $error("y_variance exp %0h got %0h", e.vy, y_variance); fail_count++;
        end
        if (covariance !== e.cov) begin
          $error("covariance exp %0h got %0h", e.cov, covariance); fail_count++;
        end
        if (series_end !== e.fin) begin
          $error("series_end exp %0b got %0b", e.fin, series_end); fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("running_bivariate_covariance_core test failed");
      $finish;
    end
  end

  initial begin
    wait (sending_done);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (fail_count == 0 && pending_stats.size() == 0)
      $display("running_bivariate_covariance_core test passed");
    else
      $display("running_bivariate_covariance_core test failed");
    $finish;
  end
endmodule

// ----- filelist.f -----
sv/rbc_pkg.sv
sv/rbc_div.sv
sv/running_bivariate_covariance_core.sv
test/running_bivariate_covariance_core_tb.sv
